### hdl/xml_subset_tokenizer_macros.svh
// assertion macros for the xml subset tokenizer
// expects clk and rst_n in the scope of use
`ifndef XML_SUBSET_TOKENIZER_MACROS_SVH
`define XML_SUBSET_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define XST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xst assertion failed");
`define XST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xst assertion failed");
`else
`define XST_ASSERT_IMP(lbl, ante, cons)
`define XST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/xst_pkg.sv
// types, codes and helpers for the xml subset tokenizer
// no dependencies
package xst_pkg;

  typedef enum logic [3:0] {
    M_TEXT       = 4'd0,
    M_LT         = 4'd1,
    M_BANG       = 4'd2,
    M_BANGDASH   = 4'd3,
    M_COMMENT    = 4'd4,
    M_PI         = 4'd5,
    M_DTD        = 4'd6,
    M_NAME_OPEN  = 4'd7,
    M_TAG        = 4'd8,
    M_SLASH      = 4'd9,
    M_ATTRNAME   = 4'd10,
    M_EQ         = 4'd11,
    M_QVAL       = 4'd12,
    M_UVAL       = 4'd13,
    M_ERR        = 4'd14,
    M_NAME_CLOSE = 4'd15
  } mode_t;

  typedef enum logic [2:0] {
    EV_BEGIN = 3'd0,
    EV_BYTE  = 3'd1,
    EV_END   = 3'd2,
    EV_EMPTY = 3'd3,
    EV_DOC   = 3'd4,
    EV_ERROR = 3'd5
  } ev_t;

  typedef enum logic [2:0] {
    K_TEXT  = 3'd0,
    K_OPEN  = 3'd1,
    K_CLOSE = 3'd2,
    K_ATTR  = 3'd3,
    K_VALUE = 3'd4
  } kind_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_CHAR   = 2'd2;
  localparam logic [1:0] ERR_SPACE  = 2'd3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    ev_t        ev;
    kind_t      kind;
    logic [7:0] data;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] slot;
    logic [2:0]        cnt;
  } bundle_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic res_t mk_res(ev_t ev, kind_t kind, logic [7:0] data,
                                  logic [1:0] err);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    return r;
  endfunction

  function automatic bundle_t push(bundle_t b, res_t r);
    bundle_t o;
    o = b;
    if (o.cnt < 3'(MaxRes)) begin
      o.slot[o.cnt[1:0]] = r;
      o.cnt = o.cnt + 3'd1;
    end
    return o;
  endfunction

endpackage

### hdl/xml_subset_tokenizer.sv
// top level of the xml subset tokenizer: parser, two-entry result queue, output unroll
// depends on xst_pkg, xst_parse and xml_subset_tokenizer_macros.svh
//
// input channel: one text byte per transaction on in_tdata, or an end-of-text
// mark with in_tlast high (in_tdata is then ignored). the byte is parsed in the
// cycle it is accepted and all of its results (up to three) are written as
// one bundle into a two-entry queue; an input with no result writes nothing.
// output channel: one token event per transaction. out_tlast marks the last
// event caused by one input transaction; inputs that cause no event give none.
// an input's bundle is registered in the queue and offered once older bundles leave.
// throughput: one input per cycle while each input yields at most one event and
// the receiver is ready; an input with n events occupies the output for n
// transactions, and the queue depth of two bundles sets how far input may run ahead.
// when the receiver stalls, events hold on the port and in_tready drops once
// both queue entries are taken.
// reset (rst_n low at a clock edge) returns the parser to text mode and empties
// the queue; no clearing pass is needed.
`include "xml_subset_tokenizer_macros.svh"

module xml_subset_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // byte_out [7:0], error_code [9:8], zero fill
  output logic [5:0]  out_tuser,  // event_res [2:0], token_kind [5:3]
  output logic        out_tlast   // last_of_run
);

  logic             take;
  xst_pkg::item_t   item;
  xst_pkg::bundle_t res;
  xst_pkg::bundle_t q_r [2];
  xst_pkg::bundle_t head;
  xst_pkg::res_t    cur;
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       sidx_r, sidx_nxt;
  logic             push_q, pop_ev, pop_q;

  assign in_tready = (cnt_r != 2'd2);
  assign take      = in_tvalid && in_tready;
  assign item      = '{data_byte: in_tdata, end_of_text: in_tlast};

  xst_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .res   (res)
  );

  assign push_q = take && (res.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign cur        = head.slot[sidx_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (({1'b0, sidx_r} + 3'd1) == head.cnt);
  assign out_tdata  = {6'd0, cur.err, cur.data};
  assign out_tuser  = {cur.kind, cur.ev};

  assign pop_ev = out_tvalid && out_tready;
  assign pop_q  = pop_ev && out_tlast;

  always_comb begin
    cnt_nxt  = cnt_r;
    sidx_nxt = sidx_r;
    if (push_q && !pop_q) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_q && pop_q) begin
      cnt_nxt = cnt_r - 2'd1;
    end
    if (pop_q) begin
      sidx_nxt = 2'd0;
    end else if (pop_ev) begin
      sidx_nxt = sidx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sidx_r   <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_q) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r  <= cnt_nxt;
      sidx_r <= sidx_nxt;
    end
  end

  `XST_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r != 2'd3)
  `XST_ASSERT_IMP(a_head_nonempty, out_tvalid, head.cnt != 3'd0)
  `XST_ASSERT_IMP(a_slot_in_range, out_tvalid, {1'b0, sidx_r} < head.cnt)
  `XST_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(sidx_r))

endmodule

### hdl/xst_parse.sv
// mode machine of the tokenizer: one byte per transaction in, a bundle of results out
// depends on xst_pkg
module xst_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  xst_pkg::item_t   item,
  output xst_pkg::bundle_t res
);

  xst_pkg::mode_t mode_r, mode_nxt;
  logic           qdbl_r, qdbl_nxt;
  logic [1:0]     dash_r, dash_nxt;
  logic           space_r, space_nxt;
  logic           tok_r, tok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= xst_pkg::M_TEXT;
      qdbl_r  <= 1'b0;
      dash_r  <= 2'd0;
      space_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      qdbl_r  <= qdbl_nxt;
      dash_r  <= dash_nxt;
      space_r <= space_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_comb begin
    xst_pkg::bundle_t b;
    logic [7:0]       c;
    logic             do_tag;
    logic             do_name;
    xst_pkg::kind_t   name_kind;
    b         = '0;
    c         = item.data_byte;
    do_tag    = 1'b0;
    do_name   = 1'b0;
    name_kind = xst_pkg::K_OPEN;
    mode_nxt  = mode_r;
    qdbl_nxt  = qdbl_r;
    dash_nxt  = dash_r;
    space_nxt = space_r;
    tok_nxt   = tok_r;
    if (take && item.end_of_text) begin
      case (mode_r)
        xst_pkg::M_TEXT: begin
          if (tok_r) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_TEXT, 8'd0,
                                                 xst_pkg::ERR_NONE));
          end
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_DOC, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_NONE));
        end
        xst_pkg::M_TAG: begin
          if (space_r) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_ERROR, xst_pkg::K_TEXT, 8'd0,
                                                 xst_pkg::ERR_SPACE));
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_DOC, xst_pkg::K_TEXT, 8'd0,
                                                 xst_pkg::ERR_NONE));
          end
        end
        xst_pkg::M_SLASH: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_ERROR, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_CHAR));
        end
        xst_pkg::M_ATTRNAME: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_ATTR, 8'd0,
                                               xst_pkg::ERR_NONE));
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_DOC, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_NONE));
        end
        xst_pkg::M_EQ: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_VALUE, 8'd0,
                                               xst_pkg::ERR_NONE));
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_VALUE, 8'd0,
                                               xst_pkg::ERR_NONE));
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_DOC, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_NONE));
        end
        xst_pkg::M_UVAL: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_VALUE, 8'd0,
                                               xst_pkg::ERR_NONE));
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_DOC, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_NONE));
        end
        xst_pkg::M_ERR: begin
        end
        default: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_ERROR, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_UNTERM));
        end
      endcase
      mode_nxt  = xst_pkg::M_TEXT;
      qdbl_nxt  = 1'b0;
      dash_nxt  = 2'd0;
      space_nxt = 1'b0;
      tok_nxt   = 1'b0;
    end else if (take) begin
      case (mode_r)
        xst_pkg::M_LT: begin
          if (c == xst_pkg::CH_BANG) begin
            mode_nxt = xst_pkg::M_BANG;
          end else if (c == xst_pkg::CH_QMARK) begin
            mode_nxt = xst_pkg::M_PI;
            dash_nxt = 2'd0;
          end else if (c == xst_pkg::CH_SLASH) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_CLOSE, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt  = 1'b1;
            mode_nxt = xst_pkg::M_NAME_CLOSE;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_OPEN, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt   = 1'b1;
            mode_nxt  = xst_pkg::M_NAME_OPEN;
            do_name   = 1'b1;
            name_kind = xst_pkg::K_OPEN;
          end
        end
        xst_pkg::M_BANG: begin
          if (c == xst_pkg::CH_DASH) begin
            mode_nxt = xst_pkg::M_BANGDASH;
          end else if (c == xst_pkg::CH_GT) begin
            mode_nxt = xst_pkg::M_TEXT;
          end else begin
            mode_nxt = xst_pkg::M_DTD;
          end
        end
        xst_pkg::M_BANGDASH: begin
          if (c == xst_pkg::CH_DASH) begin
            mode_nxt = xst_pkg::M_COMMENT;
            dash_nxt = 2'd0;
          end else if (c == xst_pkg::CH_GT) begin
            mode_nxt = xst_pkg::M_TEXT;
          end else begin
            mode_nxt = xst_pkg::M_DTD;
          end
        end
        xst_pkg::M_COMMENT: begin
          if (c == xst_pkg::CH_DASH) begin
            if (dash_r < 2'd2) begin
              dash_nxt = dash_r + 2'd1;
            end
          end else begin
            if (c == xst_pkg::CH_GT && dash_r == 2'd2) begin
              mode_nxt = xst_pkg::M_TEXT;
            end
            dash_nxt = 2'd0;
          end
        end
        xst_pkg::M_PI: begin
          if (c == xst_pkg::CH_QMARK) begin
            dash_nxt = 2'd1;
          end else begin
            if (c == xst_pkg::CH_GT && dash_r == 2'd1) begin
              mode_nxt = xst_pkg::M_TEXT;
            end
            dash_nxt = 2'd0;
          end
        end
        xst_pkg::M_DTD: begin
          if (c == xst_pkg::CH_GT) begin
            mode_nxt = xst_pkg::M_TEXT;
          end
        end
        xst_pkg::M_NAME_OPEN: begin
          do_name   = 1'b1;
          name_kind = xst_pkg::K_OPEN;
        end
        xst_pkg::M_NAME_CLOSE: begin
          do_name   = 1'b1;
          name_kind = xst_pkg::K_CLOSE;
        end
        xst_pkg::M_TAG: begin
          do_tag = 1'b1;
        end
        xst_pkg::M_SLASH: begin
          if (c == xst_pkg::CH_GT) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_EMPTY, xst_pkg::K_TEXT, 8'd0,
                                                 xst_pkg::ERR_NONE));
            mode_nxt  = xst_pkg::M_TEXT;
            space_nxt = 1'b0;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_ERROR, xst_pkg::K_TEXT, 8'd0,
                                                 xst_pkg::ERR_CHAR));
            mode_nxt = xst_pkg::M_ERR;
            tok_nxt  = 1'b0;
          end
        end
        xst_pkg::M_ATTRNAME: begin
          if (c == xst_pkg::CH_EQ) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_ATTR, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt  = 1'b0;
            mode_nxt = xst_pkg::M_EQ;
          end else if (xst_pkg::is_ws(c) || c == xst_pkg::CH_SLASH ||
                       c == xst_pkg::CH_GT) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_ATTR, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt   = 1'b0;
            mode_nxt  = xst_pkg::M_TAG;
            space_nxt = 1'b0;
            do_tag    = 1'b1;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_ATTR, c,
                                                 xst_pkg::ERR_NONE));
          end
        end
        xst_pkg::M_EQ: begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_VALUE, 8'd0,
                                               xst_pkg::ERR_NONE));
          tok_nxt = 1'b1;
          if (c == xst_pkg::CH_SQ || c == xst_pkg::CH_DQ) begin
            qdbl_nxt = (c == xst_pkg::CH_DQ);
            mode_nxt = xst_pkg::M_QVAL;
          end else if (xst_pkg::is_ws(c) || c == xst_pkg::CH_GT) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_VALUE, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt   = 1'b0;
            mode_nxt  = xst_pkg::M_TAG;
            space_nxt = 1'b0;
            do_tag    = 1'b1;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_VALUE, c,
                                                 xst_pkg::ERR_NONE));
            mode_nxt = xst_pkg::M_UVAL;
          end
        end
        xst_pkg::M_QVAL: begin
          if (c == (qdbl_r ? xst_pkg::CH_DQ : xst_pkg::CH_SQ)) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_VALUE, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt   = 1'b0;
            mode_nxt  = xst_pkg::M_TAG;
            space_nxt = 1'b0;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_VALUE, c,
                                                 xst_pkg::ERR_NONE));
          end
        end
        xst_pkg::M_UVAL: begin
          if (xst_pkg::is_ws(c) || c == xst_pkg::CH_GT) begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_VALUE, 8'd0,
                                                 xst_pkg::ERR_NONE));
            tok_nxt   = 1'b0;
            mode_nxt  = xst_pkg::M_TAG;
            space_nxt = 1'b0;
            do_tag    = 1'b1;
          end else begin
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_VALUE, c,
                                                 xst_pkg::ERR_NONE));
          end
        end
        xst_pkg::M_ERR: begin
        end
        default: begin
          if (c == xst_pkg::CH_LT) begin
            if (tok_r) begin
              b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, xst_pkg::K_TEXT, 8'd0,
                                                   xst_pkg::ERR_NONE));
              tok_nxt = 1'b0;
            end
            mode_nxt = xst_pkg::M_LT;
          end else begin
            mode_nxt = xst_pkg::M_TEXT;
            if (!tok_r) begin
              b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_TEXT, 8'd0,
                                                   xst_pkg::ERR_NONE));
              tok_nxt = 1'b1;
            end
            b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_TEXT, c,
                                                 xst_pkg::ERR_NONE));
          end
        end
      endcase

      // name byte: a delimiter closes the name and falls into the tag
      if (do_name) begin
        if (xst_pkg::is_ws(c) || c == xst_pkg::CH_SLASH || c == xst_pkg::CH_GT) begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_END, name_kind, 8'd0,
                                               xst_pkg::ERR_NONE));
          tok_nxt   = 1'b0;
          mode_nxt  = xst_pkg::M_TAG;
          space_nxt = 1'b0;
          do_tag    = 1'b1;
        end else begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, name_kind, c,
                                               xst_pkg::ERR_NONE));
        end
      end

      // byte inside a tag, between tokens
      if (do_tag) begin
        if (xst_pkg::is_ws(c)) begin
          space_nxt = 1'b1;
        end else if (c == xst_pkg::CH_GT) begin
          mode_nxt  = xst_pkg::M_TEXT;
          space_nxt = 1'b0;
        end else if (c == xst_pkg::CH_SLASH) begin
          mode_nxt = xst_pkg::M_SLASH;
        end else if (c == xst_pkg::CH_EQ) begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_ERROR, xst_pkg::K_TEXT, 8'd0,
                                               xst_pkg::ERR_CHAR));
          mode_nxt = xst_pkg::M_ERR;
          tok_nxt  = 1'b0;
        end else begin
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BEGIN, xst_pkg::K_ATTR, 8'd0,
                                               xst_pkg::ERR_NONE));
          b = xst_pkg::push(b, xst_pkg::mk_res(xst_pkg::EV_BYTE, xst_pkg::K_ATTR, c,
                                               xst_pkg::ERR_NONE));
          tok_nxt   = 1'b1;
          mode_nxt  = xst_pkg::M_ATTRNAME;
          space_nxt = 1'b0;
        end
      end
    end
    res = b;
  end

endmodule
